// ===== design/mof_pkg.sv =====
package mof_pkg;

    localparam int WINDOW_DEF      = 21;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic {
        AXIS_X = 1'b0,
        AXIS_Y = 1'b1
    } axis_t;

    function automatic int tdata_width(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

// ===== design/mof_front.sv =====
module mof_front #(
    parameter int WINDOW      = 21,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    output logic                   push_valid,
    input  logic                   push_ready,
    output logic [SAMPLE_BITS:0]   push_data
);

    localparam int POS_W = $clog2(WINDOW + 1);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             last_in_window;
    logic             accept;

    assign in_ready       = push_ready;
    assign push_valid     = in_valid;
    assign accept         = in_valid && push_ready;
    assign last_in_window = (pos_reg == POS_W'(WINDOW - 1));
    // top bit marks the sample that completes a window
    assign push_data      = {last_in_window, in_sample};

    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            pos_next = last_in_window ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg < POS_W'(WINDOW))
        else $error("window position out of range");

    a_pos_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last_in_window |=> pos_reg == '0)
        else $error("window position did not wrap");

    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(pos_reg))
        else $error("window position moved without a transfer");
`endif

endmodule

// ===== design/mof_queue.sv =====
module mof_queue #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;
    logic             pop;

    assign in_ready  = (cnt_reg != CNT_W'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0 || cnt_reg == CNT_W'(DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

    a_cnt_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count did not follow a push");
`endif

endmodule

// ===== design/mof_back.sv =====
module mof_back #(
    parameter int WINDOW      = 21,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  logic [SAMPLE_BITS:0]   pop_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_median,
    output logic                   out_axis
);
    import mof_pkg::*;

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int MID   = (WINDOW - 1) / 2;

    logic [SAMPLE_BITS-1:0] sort_reg  [WINDOW];
    logic [SAMPLE_BITS-1:0] sort_next [WINDOW];
    logic [WINDOW-1:0]      gt;
    logic [WINDOW-1:0]      ins;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    axis_t                  axis_reg, axis_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] median_reg;
    axis_t                  out_axis_reg;
    logic [SAMPLE_BITS-1:0] x;
    logic                   x_last;
    logic                   pop;
    logic                   pop_last;

    assign x        = pop_data[SAMPLE_BITS-1:0];
    assign x_last   = pop_data[SAMPLE_BITS];
    assign pop_ready = !x_last || !out_valid_reg || out_ready;
    assign pop      = pop_valid && pop_ready;
    assign pop_last = pop && x_last;

    // insertion cells: each compares its entry against the new sample
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        assign gt[g]  = (CNT_W'(g) < cnt_reg) && (sort_reg[g] > x);
        assign ins[g] = (CNT_W'(g) < cnt_reg) ? gt[g] : (CNT_W'(g) == cnt_reg);
        if (g == 0) begin : g_first
            assign sort_next[g] = ins[g] ? x : sort_reg[g];
        end else begin : g_rest
            assign sort_next[g] = gt[g-1] ? sort_reg[g-1] : (ins[g] ? x : sort_reg[g]);
        end
    end

    always_comb begin
        cnt_next  = cnt_reg;
        axis_next = axis_reg;
        if (pop) begin
            cnt_next = x_last ? '0 : cnt_reg + 1'b1;
        end
        if (pop_last) begin
            axis_next = (axis_reg == AXIS_X) ? AXIS_Y : AXIS_X;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop_last) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            for (int i = 0; i < WINDOW; i++) begin
                sort_reg[i] <= sort_next[i];
            end
        end
        if (pop_last) begin
            median_reg   <= sort_next[MID];
            out_axis_reg <= axis_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            axis_reg      <= AXIS_X;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_median = median_reg;
    assign out_axis   = out_axis_reg;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < CNT_W'(WINDOW))
        else $error("sorted window count out of range");

    a_last_at_full: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (x_last == (cnt_reg == CNT_W'(WINDOW - 1))))
        else $error("window end tag out of step with sorted count");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_last |=> out_valid_reg && cnt_reg == '0)
        else $error("completed window gave no result");

    a_axis_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_last |=> axis_reg != $past(axis_reg))
        else $error("axis did not alternate");
`endif

endmodule

// ===== design/median_of_window_filter.sv =====
// median of window filter for touch-panel adc samples
//
// input stream: one sample per transfer on s_axis, low SAMPLE_BITS of tdata
// output stream: one median per WINDOW input samples on m_axis; tdata holds
// the median, tuser the axis (0 for x, 1 for y), windows alternate x then y
//
// samples are inserted into a sorted register row as they arrive, one per
// cycle while the row is not held by a waiting median, so throughput is one
// sample per cycle outside such stalls, set by the row's insertion step
// output timing: the sample that completes the window is first written into
// the queue; its insertion step, once m_axis can take a new median, loads the
// output register and raises m_axis_tvalid
//
// reset clears the window position, axis (back to x) and all valid flags;
// no clearing pass is needed
// when m_axis stalls, samples keep entering and being sorted until a window
// completes while the previous median still waits; that sample then waits in
// the queue, and once the queue fills s_axis_tready drops
module median_of_window_filter #(
    parameter int WINDOW      = mof_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = mof_pkg::SAMPLE_BITS_DEF,
    parameter int QUEUE_DEPTH = mof_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            s_axis_tvalid,
    output logic                                            s_axis_tready,
    // sample, zero fill
    input  logic [mof_pkg::tdata_width(SAMPLE_BITS)-1:0]    s_axis_tdata,
    output logic                                            m_axis_tvalid,
    input  logic                                            m_axis_tready,
    // median, zero fill
    output logic [mof_pkg::tdata_width(SAMPLE_BITS)-1:0]    m_axis_tdata,
    // axis
    output logic                                            m_axis_tuser
);
    import mof_pkg::*;

    localparam int TD_W = tdata_width(SAMPLE_BITS);

    logic                   push_valid;
    logic                   push_ready;
    logic [SAMPLE_BITS:0]   push_data;
    logic                   q_valid;
    logic                   q_ready;
    logic [SAMPLE_BITS:0]   q_data;
    logic [SAMPLE_BITS-1:0] median;

    mof_front #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mof_queue #(
        .WIDTH (SAMPLE_BITS + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    mof_back #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_median (median),
        .out_axis   (m_axis_tuser)
    );

    assign m_axis_tdata = TD_W'(median);

endmodule
